### rtl/core/b2bcd_pkg.sv
// ----------------------------------------------------------------------------
// b2bcd_pkg
// Shared widths, constants and item types of the binary to packed BCD block.
// ----------------------------------------------------------------------------
`default_nettype none
package b2bcd_pkg;
	localparam int VALUE_W     = 64;
	localparam int MAX_DIGITS  = 20;
	localparam int DIG_VEC_W   = MAX_DIGITS * 4;
	localparam int NUM_STAGES  = 8;
	localparam int BITS_PER_ST = VALUE_W / NUM_STAGES;

	typedef struct packed {
		logic [63:0] value;
		logic [4:0]  digits_requested;
	} bcd_in_t;

	typedef struct packed {
		logic [7:0] bcd_byte;
		logic [3:0] byte_index;
		logic [4:0] digit_count;
		logic       last;
	} bcd_out_t;

	// One shift-add-3 step over the whole digit vector with one new bit.
	function automatic logic [DIG_VEC_W-1:0] dd_step(input logic [DIG_VEC_W-1:0] d,
		input logic b);
		logic [DIG_VEC_W-1:0] a;
		a = d;
		for (int k = 0; k < MAX_DIGITS; k++) begin
			if (a[k*4 +: 4] >= 4'd5)
				a[k*4 +: 4] = a[k*4 +: 4] + 4'd3;
		end
		return {a[DIG_VEC_W-2:0], b};
	endfunction
endpackage
`default_nettype wire

### rtl/core/bcd_in_if.sv
// ----------------------------------------------------------------------------
// bcd_in_if
// Input channel: valid, ready and one conversion request.
// ----------------------------------------------------------------------------
`default_nettype none
interface bcd_in_if;
	logic                valid;
	logic                ready;
	b2bcd_pkg::bcd_in_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/bcd_out_if.sv
// ----------------------------------------------------------------------------
// bcd_out_if
// Output channel: valid, ready and one packed BCD byte.
// ----------------------------------------------------------------------------
`default_nettype none
interface bcd_out_if;
	logic                valid;
	logic                ready;
	b2bcd_pkg::bcd_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/b2bcd_dd_pipe.sv
// ----------------------------------------------------------------------------
// b2bcd_dd_pipe
// Double-dabble pipeline: eight stages of eight bits each, stallable.
// ----------------------------------------------------------------------------
`default_nettype none
module b2bcd_dd_pipe (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [63:0]                        in_value,
	input  wire logic [4:0]                         in_req,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [b2bcd_pkg::DIG_VEC_W-1:0]         out_digits,
	output logic [4:0]                              out_req
);
	localparam int NS = b2bcd_pkg::NUM_STAGES;
	localparam int BS = b2bcd_pkg::BITS_PER_ST;

	logic [NS-1:0]                       vld_s1;
	logic [NS-1:0][63:0]                 bits_s1;
	logic [NS-1:0][b2bcd_pkg::DIG_VEC_W-1:0] dig_s1;
	logic [NS-1:0][4:0]                  req_s1;
	logic [NS-1:0]                       adv;

	always_comb begin
		adv[NS-1] = !vld_s1[NS-1] || out_ready;
		for (int s = NS - 2; s >= 0; s--)
			adv[s] = !vld_s1[s] || adv[s+1];
	end

	assign in_ready   = adv[0];
	assign out_valid  = vld_s1[NS-1];
	assign out_digits = dig_s1[NS-1];
	assign out_req    = req_s1[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= '0;
		end else begin
			if (adv[0])
				vld_s1[0] <= in_valid;
			for (int s = 1; s < NS; s++) begin
				if (adv[s])
					vld_s1[s] <= vld_s1[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [b2bcd_pkg::DIG_VEC_W-1:0] d;
		logic [63:0]                     b;
		if (adv[0]) begin
			d = '0;
			b = in_value;
			for (int k = 0; k < BS; k++) begin
				d = b2bcd_pkg::dd_step(d, b[63]);
				b = {b[62:0], 1'b0};
			end
			dig_s1[0]  <= d;
			bits_s1[0] <= b;
			req_s1[0]  <= in_req;
		end
		for (int s = 1; s < NS; s++) begin
			if (adv[s]) begin
				d = dig_s1[s-1];
				b = bits_s1[s-1];
				for (int k = 0; k < BS; k++) begin
					d = b2bcd_pkg::dd_step(d, b[63]);
					b = {b[62:0], 1'b0};
				end
				dig_s1[s]  <= d;
				bits_s1[s] <= b;
				req_s1[s]  <= req_s1[s-1];
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/b2bcd_emit.sv
// ----------------------------------------------------------------------------
// b2bcd_emit
// Count selection and byte serializer with an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module b2bcd_emit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [b2bcd_pkg::DIG_VEC_W-1:0] in_digits,
	input  wire logic [4:0]                     in_req,
	bcd_out_if.source                           res
);
	logic                              busy_q;
	logic [b2bcd_pkg::DIG_VEC_W-1:0]   dig_q;
	logic [4:0]                        n_q;
	logic [3:0]                        idx_q;
	logic [4:0]                        auto_n;
	logic [4:0]                        n_sel;
	logic [b2bcd_pkg::DIG_VEC_W+3:0]   pad;
	logic [6:0]                        sh;
	logic                              is_last;

	always_comb begin
		auto_n = 5'd1;
		for (int k = 1; k < b2bcd_pkg::MAX_DIGITS; k++) begin
			if (in_digits[k*4 +: 4] != 4'd0)
				auto_n = 5'(k + 1);
		end
		if (in_req == 5'd0)
			n_sel = auto_n;
		else if (in_req > 5'(b2bcd_pkg::MAX_DIGITS))
			n_sel = 5'(b2bcd_pkg::MAX_DIGITS);
		else
			n_sel = in_req;
	end

	// digit at left position p is dig[n-1-p]; shift pad by 4*(n-1-2*idx)
	always_comb begin
		pad = {dig_q, 4'd0};
		sh  = 7'({n_q, 2'b00}) - 7'({idx_q, 3'b000}) - 7'd4;
		is_last = ({1'b0, idx_q} + 5'd1) == ((n_q + 5'd1) >> 1);
	end

	assign in_ready = !busy_q;
	assign res.valid = busy_q;
	assign res.data.bcd_byte    = 8'(pad >> sh);
	assign res.data.byte_index  = idx_q;
	assign res.data.digit_count = n_q;
	assign res.data.last        = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end else if (res.ready) begin
			if (is_last)
				busy_q <= 1'b0;
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			dig_q <= in_digits;
			n_q   <= n_sel;
		end
	end
endmodule
`default_nettype wire

### rtl/core/binary_to_packed_bcd.sv
// ----------------------------------------------------------------------------
// binary_to_packed_bcd
// 64-bit binary to left-aligned packed BCD, one byte per output item.
// ----------------------------------------------------------------------------
// An item enters an eight-stage shift-add-3 pipeline, one stage per eight
// input bits, that accepts a new item every cycle unless stalled; the byte
// serializer then sends (count+1)/2 items, one per cycle while res.ready is
// high, and returns to idle before it takes the next conversion, so the
// serializer sets the sustained rate. The first byte is presented once the
// item has passed the pipeline stages and the serializer register. A
// requested count of zero gives the fewest digits; counts above 20 saturate to 20.
`default_nettype none
module binary_to_packed_bcd (
	input  wire logic clk,
	input  wire logic arst_n,
	bcd_in_if.sink    req,
	bcd_out_if.source res
);
	logic                             p_valid;
	logic                             p_ready;
	logic [b2bcd_pkg::DIG_VEC_W-1:0]  p_digits;
	logic [4:0]                       p_req;

	b2bcd_dd_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.in_value   (req.data.value),
		.in_req     (req.data.digits_requested),
		.out_valid  (p_valid),
		.out_ready  (p_ready),
		.out_digits (p_digits),
		.out_req    (p_req)
	);

	b2bcd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_valid),
		.in_ready  (p_ready),
		.in_digits (p_digits),
		.in_req    (p_req),
		.res       (res)
	);
endmodule
`default_nettype wire
